FILE: design/bsap_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bsap_pkg: shared types and constants of the sensor advertisement parser
// Holds the parse phases, controller states, result kinds, frame status
// codes, object type codes and the command and status structs.
// ============================================================================
package bsap_pkg;

  // Default depth of the text buffer.
  localparam int TEXT_MAX_DEFAULT = 32;

  // Configuration port geometry and register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 48;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ADDRESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SENSOR_ENABLES   = 1'b1;

  // Sensor enable bits.
  localparam int EN_BATTERY     = 0;
  localparam int EN_TEMPERATURE = 1;
  localparam int EN_HUMIDITY    = 2;
  localparam int EN_BATTERY_LOW = 3;
  localparam int EN_TEXT        = 4;

  // Header flag bits captured from the first byte.
  localparam int HF_ENCRYPTED = 0;
  localparam int HF_MAC       = 1;
  localparam int HF_VERSION   = 2;

  // Header version field value that is accepted.
  localparam logic [2:0] HEADER_VERSION = 3'd2;

  // Object type codes.
  localparam logic [7:0] TYPE_PACKET_ID   = 8'h00;
  localparam logic [7:0] TYPE_BATTERY     = 8'h01;
  localparam logic [7:0] TYPE_TEMPERATURE = 8'h02;
  localparam logic [7:0] TYPE_HUMIDITY    = 8'h03;
  localparam logic [7:0] TYPE_BATTERY_LOW = 8'h15;
  localparam logic [7:0] TYPE_TEXT        = 8'h53;
  localparam logic [7:0] TYPE_RAW         = 8'hF1;

  // Parse phase of the current frame.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEAD,
    PH_TYPE,
    PH_LEN,
    PH_VAL,
    PH_STOP
  } phase_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_BATTERY,
    KIND_TEMPERATURE,
    KIND_HUMIDITY,
    KIND_BATTERY_LOW,
    KIND_TEXT,
    KIND_FRAME_END
  } kind_t;

  // Frame status codes.
  typedef enum logic [3:0] {
    ST_OK,
    ST_NONE,
    ST_UUID,
    ST_SHORT,
    ST_VERSION,
    ST_ENCRYPTED,
    ST_MAC,
    ST_ADDRESS,
    ST_EMPTY,
    ST_UNKNOWN,
    ST_DUP,
    ST_TRUNC
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_VALUE,
    CS_TEXT_RD,
    CS_TEXT_WR,
    CS_END
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_value;
    logic load_text;
    logic load_end;
    logic text_next;
  } bsap_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic step_value;
    logic step_text;
    logic step_end;
    logic end_pend;
    logic out_free;
    logic text_last;
  } bsap_stat_t;

endpackage

FILE: design/ble_sensor_advert_parser_core.sv
`timescale 1ns / 1ps
// ============================================================================
// ble_sensor_advert_parser_core: sensor advertisement service-data parser
// Checks the frame header and address, then decodes type-length-value
// objects into sensor results, text byte runs and a frame-end status.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready): one service-data byte per beat with
//   frame marks; the UUID flag and advertiser address go with the first byte.
//   Output channel (out_valid/out_ready): one result per beat, held in an
//   output register so the next input beat can be taken while it waits.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 expected address, 1 sensor enables); write only while idle.
// Flow, with out_ready high:
//   A byte that causes no result is taken every cycle. A byte that causes
//   results holds in_ready low while they are moved out: a sensor value,
//   then the frame end when the same byte ends the frame. A completed text
//   object replays its buffered bytes one at a time (read address, then
//   registered read data), then the frame end when that byte ends the frame.
//   A sensor value enters the output register in the cycle after its byte
//   is accepted; a text byte first passes the registered RAM read.
// Reset: synchronous; clears the parse state, the remembered packet id,
//   the configuration and the output valid flag. The text RAM is not cleared.
// Stall: while out_ready is low the pending results wait in order and
//   in_ready stays low until the last one has entered the output register.
// ============================================================================
module ble_sensor_advert_parser_core
  import bsap_pkg::*;
#(
  parameter int TEXT_MAX = TEXT_MAX_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  input  logic                   first_of_frame,
  input  logic                   last_of_frame,
  input  logic                   uuid_is_sensor_service,
  input  logic [47:0]            advertiser_address,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             kind,
  output logic signed [16:0]     value,
  output logic                   text_truncated,
  output logic                   last_of_run,
  output logic [3:0]             status,
  output logic                   reported
);

  bsap_cmd_t   cmd;
  bsap_stat_t  stat;
  logic [16:0] value_bits;

  // Sequencing controller.
  bsap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Parse datapath with text buffer and output register.
  bsap_datapath #(
    .TEXT_MAX (TEXT_MAX)
  ) u_datapath (
    .clk                    (clk),
    .rst                    (rst),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .data_byte              (data_byte),
    .first_of_frame         (first_of_frame),
    .last_of_frame          (last_of_frame),
    .uuid_is_sensor_service (uuid_is_sensor_service),
    .advertiser_address     (advertiser_address),
    .cmd                    (cmd),
    .stat                   (stat),
    .out_ready              (out_ready),
    .out_valid              (out_valid),
    .kind                   (kind),
    .value                  (value_bits),
    .text_truncated         (text_truncated),
    .last_of_run            (last_of_run),
    .status                 (status),
    .reported               (reported)
  );

  assign value = signed'(value_bits);

endmodule

FILE: design/bsap_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// bsap_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ============================================================================
module bsap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/bsap_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// bsap_ctrl: sequencing controller of the advertisement parser
// Accepts one input beat at a time and then moves the results it caused
// (a sensor value, a text run, a frame end) into the output register.
// ============================================================================
module bsap_ctrl
  import bsap_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  bsap_stat_t stat,
  output bsap_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (in_valid) begin
          priority if (stat.step_value) state_next = CS_VALUE;
          else if (stat.step_text) state_next = CS_TEXT_RD;
          else if (stat.step_end) state_next = CS_END;
          else state_next = CS_IDLE;
        end
      end
      CS_VALUE: begin
        if (stat.out_free) begin
          state_next = stat.end_pend ? CS_END : CS_IDLE;
        end
      end
      CS_TEXT_RD: begin
        state_next = CS_TEXT_WR;
      end
      CS_TEXT_WR: begin
        if (stat.out_free) begin
          if (stat.text_last) begin
            state_next = stat.end_pend ? CS_END : CS_IDLE;
          end else begin
            state_next = CS_TEXT_RD;
          end
        end
      end
      CS_END: begin
        if (stat.out_free) begin
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready       = (state == CS_IDLE);
    cmd.accept     = (state == CS_IDLE) && in_valid;
    cmd.load_value = (state == CS_VALUE) && stat.out_free;
    cmd.load_text  = (state == CS_TEXT_WR) && stat.out_free;
    cmd.text_next  = (state == CS_TEXT_WR) && stat.out_free && !stat.text_last;
    cmd.load_end   = (state == CS_END) && stat.out_free;
  end

  // At most one result enters the output register per cycle.
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_value, cmd.load_text, cmd.load_end}))
    else $error("more than one result loaded in a cycle");

  // A frame end is only loaded when one was recorded at accept time.
  a_end_recorded: assert property (@(posedge clk) disable iff (rst)
    cmd.load_end |-> stat.end_pend)
    else $error("frame end loaded without a pending frame end");

  // A text byte that is not the last is followed by a fetch of the next one.
  a_text_refetch: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_text && !stat.text_last) |=> (state == CS_TEXT_RD))
    else $error("text run did not continue");

  // After the frame end goes out, the block takes input again.
  a_ready_after_end: assert property (@(posedge clk) disable iff (rst)
    cmd.load_end |=> in_ready)
    else $error("input not ready after frame end");

endmodule

FILE: design/bsap_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// bsap_datapath: parse state, text buffer and output register
// Decodes each accepted byte against the frame header and object stream,
// records the results it causes and drives the output register.
// ============================================================================
module bsap_datapath
  import bsap_pkg::*;
#(
  parameter int TEXT_MAX = TEXT_MAX_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]             data_byte,
  input  logic                   first_of_frame,
  input  logic                   last_of_frame,
  input  logic                   uuid_is_sensor_service,
  input  logic [47:0]            advertiser_address,
  input  bsap_cmd_t              cmd,
  output bsap_stat_t             stat,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [2:0]             kind,
  output logic [16:0]            value,
  output logic                   text_truncated,
  output logic                   last_of_run,
  output logic [3:0]             status,
  output logic                   reported
);

  localparam int CW = $clog2(TEXT_MAX + 1);
  localparam int AW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;

  // Configuration registers.
  logic [47:0] expected_address;
  logic [4:0]  sensor_enables;

  // Parse state.
  phase_t      phase, phase_next;
  logic [2:0]  byte_cnt, byte_cnt_next;
  logic [2:0]  hflags, hflags_next;
  logic [47:0] addr_shift, addr_shift_next;
  logic [7:0]  ctype, ctype_next;
  logic [7:0]  bleft, bleft_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [CW-1:0] text_count, text_count_next;
  logic        text_ovf, text_ovf_next;
  logic [7:0]  prior_id, prior_id_next;
  logic        prior_valid, prior_valid_next;
  logic        frame_rep, frame_rep_next;
  status_t     stop_code, stop_code_next;

  // Results recorded at accept time.
  kind_t       pv_kind, val_kind;
  logic [16:0] pv_value, val_value;
  logic        end_pend;
  status_t     end_status, end_st;
  logic        end_rep;
  logic [CW-1:0] text_idx;

  // Output register.
  logic        out_free;
  kind_t       out_kind;
  logic [16:0] out_value;
  logic        out_trunc;
  logic        out_last;
  status_t     out_status;
  logic        out_rep;

  // Step decode helpers.
  logic        active;
  logic        do_type;
  logic        text_we;
  logic        step_value, step_text, step_end;
  logic [47:0] shifted;
  logic [7:0]  bl_dec;
  logic        is_text;
  logic [15:0] raw;
  logic [7:0]  rd_data;

  assign active   = first_of_frame || (phase != PH_IDLE);
  assign shifted  = {data_byte, addr_shift[47:8]};
  assign bl_dec   = (bleft != 8'd0) ? (bleft - 8'd1) : 8'd0;
  assign is_text  = (ctype == TYPE_TEXT) || (ctype == TYPE_RAW);
  assign raw      = {data_byte, low_byte};
  assign out_free = !out_valid || out_ready;

  // Next parse state for the byte at the input.
  always_comb begin
    phase_next       = phase;
    byte_cnt_next    = byte_cnt;
    hflags_next      = hflags;
    addr_shift_next  = addr_shift;
    ctype_next       = ctype;
    bleft_next       = bleft;
    low_byte_next    = low_byte;
    text_count_next  = text_count;
    text_ovf_next    = text_ovf;
    prior_id_next    = prior_id;
    prior_valid_next = prior_valid;
    frame_rep_next   = frame_rep;
    stop_code_next   = stop_code;
    do_type          = 1'b0;
    text_we          = 1'b0;
    step_value       = 1'b0;
    step_text        = 1'b0;
    step_end         = 1'b0;
    val_kind         = KIND_BATTERY;
    val_value        = '0;
    end_st           = ST_OK;

    if (first_of_frame) begin
      // A first byte opens a new frame and carries the header flags.
      byte_cnt_next   = 3'd0;
      frame_rep_next  = 1'b0;
      text_count_next = '0;
      text_ovf_next   = 1'b0;
      bleft_next      = 8'd0;
      ctype_next      = 8'd0;
      low_byte_next   = 8'd0;
      addr_shift_next = advertiser_address;
      hflags_next     = {(data_byte[7:5] == HEADER_VERSION), data_byte[1], data_byte[0]};
      if (uuid_is_sensor_service) begin
        stop_code_next = ST_OK;
        phase_next     = PH_HEAD;
      end else begin
        stop_code_next = ST_UUID;
        phase_next     = PH_STOP;
      end
    end else if (phase != PH_IDLE) begin
      unique case (phase)
        PH_HEAD: begin
          priority if (byte_cnt == 3'd1 && !hflags[HF_VERSION]) begin
            stop_code_next = ST_VERSION;
            phase_next     = PH_STOP;
          end else if (byte_cnt == 3'd1 && hflags[HF_ENCRYPTED]) begin
            stop_code_next = ST_ENCRYPTED;
            phase_next     = PH_STOP;
          end else if (byte_cnt == 3'd1 && !hflags[HF_MAC]) begin
            // No MAC: the advertiser address is checked and this is a type byte.
            if (addr_shift != expected_address) begin
              stop_code_next = ST_ADDRESS;
              phase_next     = PH_STOP;
            end else begin
              do_type = 1'b1;
            end
          end else begin
            // MAC bytes arrive least significant first.
            addr_shift_next = shifted;
            if (byte_cnt >= 3'd6) begin
              priority if (shifted != expected_address) begin
                stop_code_next = ST_ADDRESS;
                phase_next     = PH_STOP;
              end else if (last_of_frame) begin
                stop_code_next = ST_EMPTY;
                phase_next     = PH_STOP;
              end else begin
                phase_next = PH_TYPE;
              end
            end
          end
        end
        PH_TYPE: begin
          do_type = 1'b1;
        end
        PH_LEN: begin
          bleft_next      = data_byte;
          text_count_next = '0;
          text_ovf_next   = 1'b0;
          phase_next      = (data_byte == 8'd0) ? PH_TYPE : PH_VAL;
        end
        PH_VAL: begin
          if (is_text) begin
            if (text_count < CW'(TEXT_MAX)) begin
              text_we         = 1'b1;
              text_count_next = text_count + CW'(1);
            end else begin
              text_ovf_next = 1'b1;
            end
          end else if (bleft == 8'd2) begin
            low_byte_next = data_byte;
          end
          bleft_next = bl_dec;
          if (bl_dec == 8'd0) begin
            // The object is complete.
            phase_next = PH_TYPE;
            unique case (ctype)
              TYPE_PACKET_ID: begin
                if (prior_valid && prior_id == data_byte) begin
                  stop_code_next = ST_DUP;
                  phase_next     = PH_STOP;
                end else begin
                  prior_id_next    = data_byte;
                  prior_valid_next = 1'b1;
                end
              end
              TYPE_BATTERY: begin
                if (sensor_enables[EN_BATTERY]) begin
                  step_value     = 1'b1;
                  val_kind       = KIND_BATTERY;
                  val_value      = {9'd0, data_byte};
                  frame_rep_next = 1'b1;
                end
              end
              TYPE_TEMPERATURE: begin
                if (sensor_enables[EN_TEMPERATURE]) begin
                  step_value     = 1'b1;
                  val_kind       = KIND_TEMPERATURE;
                  val_value      = {raw[15], raw};
                  frame_rep_next = 1'b1;
                end
              end
              TYPE_HUMIDITY: begin
                if (sensor_enables[EN_HUMIDITY]) begin
                  step_value     = 1'b1;
                  val_kind       = KIND_HUMIDITY;
                  val_value      = {1'b0, raw};
                  frame_rep_next = 1'b1;
                end
              end
              TYPE_BATTERY_LOW: begin
                if (sensor_enables[EN_BATTERY_LOW]) begin
                  step_value     = 1'b1;
                  val_kind       = KIND_BATTERY_LOW;
                  val_value      = {16'd0, (data_byte != 8'd0)};
                  frame_rep_next = 1'b1;
                end
              end
              default: begin
                // Text: replay the buffered bytes when the sensor is enabled.
                if (sensor_enables[EN_TEXT] && text_count_next != '0) begin
                  step_text      = 1'b1;
                  frame_rep_next = 1'b1;
                end
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    // Type byte decode, shared by the header and the object stream.
    if (do_type) begin
      ctype_next = data_byte;
      unique case (data_byte)
        TYPE_TEXT, TYPE_RAW: begin
          phase_next = PH_LEN;
        end
        TYPE_PACKET_ID, TYPE_BATTERY, TYPE_BATTERY_LOW: begin
          bleft_next = 8'd1;
          phase_next = PH_VAL;
        end
        TYPE_TEMPERATURE, TYPE_HUMIDITY: begin
          bleft_next = 8'd2;
          phase_next = PH_VAL;
        end
        default: begin
          stop_code_next = ST_UNKNOWN;
          phase_next     = PH_STOP;
        end
      endcase
    end

    // Byte count saturates; only small values are compared.
    if (active) begin
      byte_cnt_next = (byte_cnt_next == 3'd7) ? 3'd7 : (byte_cnt_next + 3'd1);
      if (last_of_frame) begin
        step_end = 1'b1;
        unique case (phase_next)
          PH_STOP: end_st = stop_code_next;
          PH_HEAD: end_st = (byte_cnt_next <= 3'd1) ? ST_SHORT : ST_MAC;
          PH_TYPE: end_st = frame_rep_next ? ST_OK : ST_NONE;
          default: end_st = ST_TRUNC;
        endcase
        phase_next = PH_IDLE;
      end
    end
  end

  // Configuration and parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_address <= '0;
      sensor_enables   <= '0;
      phase            <= PH_IDLE;
      byte_cnt         <= '0;
      hflags           <= '0;
      addr_shift       <= '0;
      ctype            <= '0;
      bleft            <= '0;
      low_byte         <= '0;
      text_count       <= '0;
      text_ovf         <= 1'b0;
      prior_id         <= '0;
      prior_valid      <= 1'b0;
      frame_rep        <= 1'b0;
      stop_code        <= ST_OK;
      end_pend         <= 1'b0;
      text_idx         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_EXPECTED_ADDRESS: expected_address <= cfg_data[47:0];
          CFG_SENSOR_ENABLES:   sensor_enables   <= cfg_data[4:0];
          default: begin
          end
        endcase
      end
      if (cmd.accept) begin
        phase       <= phase_next;
        byte_cnt    <= byte_cnt_next;
        hflags      <= hflags_next;
        addr_shift  <= addr_shift_next;
        ctype       <= ctype_next;
        bleft       <= bleft_next;
        low_byte    <= low_byte_next;
        text_count  <= text_count_next;
        text_ovf    <= text_ovf_next;
        prior_id    <= prior_id_next;
        prior_valid <= prior_valid_next;
        frame_rep   <= frame_rep_next;
        stop_code   <= stop_code_next;
        end_pend    <= step_end;
        text_idx    <= '0;
      end else begin
        if (cmd.text_next) begin
          text_idx <= text_idx + CW'(1);
        end
        if (cmd.load_end) begin
          end_pend <= 1'b0;
        end
      end
    end
  end

  // Result payload recorded with the accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pv_kind    <= val_kind;
      pv_value   <= val_value;
      end_status <= end_st;
      end_rep    <= frame_rep_next;
    end
  end

  // Text buffer.
  bsap_ram #(
    .WIDTH (8),
    .DEPTH (TEXT_MAX)
  ) u_text_ram (
    .clk     (clk),
    .wr_en   (cmd.accept && text_we),
    .wr_addr (text_count[AW-1:0]),
    .wr_data (data_byte),
    .rd_addr (text_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_value || cmd.load_text || cmd.load_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    priority if (cmd.load_value) begin
      out_kind   <= pv_kind;
      out_value  <= pv_value;
      out_trunc  <= 1'b0;
      out_last   <= 1'b0;
      out_status <= ST_OK;
      out_rep    <= 1'b0;
    end else if (cmd.load_text) begin
      out_kind   <= KIND_TEXT;
      out_value  <= {9'd0, rd_data};
      out_trunc  <= text_ovf;
      out_last   <= stat.text_last;
      out_status <= ST_OK;
      out_rep    <= 1'b0;
    end else if (cmd.load_end) begin
      out_kind   <= KIND_FRAME_END;
      out_value  <= '0;
      out_trunc  <= 1'b0;
      out_last   <= 1'b1;
      out_status <= end_status;
      out_rep    <= end_rep;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.step_value = step_value;
    stat.step_text  = step_text;
    stat.step_end   = step_end;
    stat.end_pend   = end_pend;
    stat.out_free   = out_free;
    stat.text_last  = (CW'(text_idx + CW'(1)) == text_count);
  end

  assign kind           = out_kind;
  assign value          = out_value;
  assign text_truncated = out_trunc;
  assign last_of_run    = out_last;
  assign status         = out_status;
  assign reported       = out_rep;

endmodule
